FILE: rtl/cbts_pkg.sv
// cbts_pkg: shared constants and the sequencer state type of the CAN bit timing solver
// no dependencies; used by the top level
`timescale 1ns / 1ps
`default_nettype none

package cbts_pkg;

	localparam int MAX_SEG1_DEF = 16;
	localparam int MAX_SEG2_DEF = 8;

	localparam logic [31:0] MIN_BITRATE   = 32'd1000;
	localparam logic [31:0] FAST_BITRATE  = 32'd1000000;
	localparam logic [4:0]  FAST_QUANTA   = 5'd10;
	localparam logic [4:0]  SLOW_QUANTA   = 5'd17;
	localparam logic [10:0] MAX_PRESCALER = 11'd1024;

	// floor(1000 * a / b) > 900 is 1000 * a >= 901 * b
	localparam logic [14:0] SP_SCALE      = 15'd1000;
	localparam logic [14:0] SP_LIMIT_NEXT = 15'd901;

	localparam logic [4:0]  DIV_LAST      = 5'd31;
	localparam logic [4:0]  MIN_SEARCH    = 5'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_Q,
		ST_TRIAL,
		ST_SPLIT,
		ST_DIV_CHK,
		ST_FIN
	} state_t;

endpackage

`default_nettype wire

FILE: rtl/cbts_if.sv
// cbts_req_if and cbts_rsp_if: valid/ready channels of the CAN bit timing solver
// request carries clock and bit rate, response carries the timing result
`timescale 1ns / 1ps
`default_nettype none

interface cbts_req_if;
	logic        valid;
	logic        ready;
	logic [31:0] clock_hz;
	logic [31:0] bitrate_bps;

	modport source (output valid, output clock_hz, output bitrate_bps, input ready);
	modport sink   (input valid, input clock_hz, input bitrate_bps, output ready);
endinterface

interface cbts_rsp_if;
	logic        valid;
	logic        ready;
	logic        ok;
	logic [10:0] prescaler;
	logic [4:0]  seg1;
	logic [3:0]  seg2;
	logic        jump_width;

	modport source (output valid, output ok, output prescaler, output seg1, output seg2,
		output jump_width, input ready);
	modport sink   (input valid, input ok, input prescaler, input seg1, input seg2,
		input jump_width, output ready);
endinterface

`default_nettype wire

FILE: rtl/can_bit_timing_solver.sv
// can_bit_timing_solver: finds prescaler and bit segments for a CAN bit rate
// depends on cbts_pkg and the cbts_req_if / cbts_rsp_if interfaces
//
// usage:
//   req carries clock_hz and bitrate_bps; a request is taken when valid and
//   ready are both high. ready is high only while the sequencer is idle.
//   rsp carries ok, prescaler, seg1, seg2 and jump_width from an output
//   register; a failed search gives ok 0 and all other fields 0.
// sequence:
//   all work runs on one radix-2 restoring divider. one division forms
//   clock / bit rate, then one division per quanta count tried (1 to 15,
//   from 10 or 17 quanta downward), then the segment split and one division
//   to verify the exact bit rate, then the output register is loaded; an
//   input that is rejected at once goes straight to the output load. the
//   next request is taken in the cycle after the result is loaded. one
//   request is in work at a time.
// stall:
//   a finished result waits in the sequencer until the output register is
//   free, so rsp may hold a result while the next request is accepted.
// reset:
//   arst_n clears the sequencer and rsp.valid; a request in work is dropped and none is invented.
`timescale 1ns / 1ps
`default_nettype none

module can_bit_timing_solver #(
	parameter int MAX_SEG1 = cbts_pkg::MAX_SEG1_DEF,
	parameter int MAX_SEG2 = cbts_pkg::MAX_SEG2_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	cbts_req_if.sink       req,
	cbts_rsp_if.source     rsp
);

	localparam logic [5:0] SegSum  = 6'(MAX_SEG1 + MAX_SEG2);
	localparam logic [4:0] Seg1Max = 5'(MAX_SEG1);
	localparam logic [4:0] Seg2Max = 5'(MAX_SEG2);

	cbts_pkg::state_t state_q, state_d;

	logic [31:0] clk_q, br_q, q_q;
	logic [4:0]  s_q;
	logic [31:0] rem_q, quo_q, den_q;
	logic [4:0]  cnt_q;
	logic        ok_q;
	logic [10:0] pre_q;
	logic [4:0]  seg1_q;
	logic [3:0]  seg2_q;

	logic        rsp_valid_q, rsp_ok_q, rsp_jw_q;
	logic [10:0] rsp_pre_q;
	logic [4:0]  rsp_seg1_q;
	logic [3:0]  rsp_seg2_q;

	// shared divider step
	logic [32:0] div_shift, div_diff;
	logic        div_ge, div_last;
	logic [31:0] div_rem_nx, div_quo_nx;

	assign div_shift  = {rem_q, quo_q[31]};
	assign div_diff   = div_shift - {1'b0, den_q};
	assign div_ge     = !div_diff[32];
	assign div_rem_nx = div_ge ? div_diff[31:0] : div_shift[31:0];
	assign div_quo_nx = {quo_q[30:0], div_ge};
	assign div_last   = (cnt_q == cbts_pkg::DIV_LAST);

	// input screening
	logic [4:0] quanta_sel;
	logic       early_fail;

	assign quanta_sel = (req.bitrate_bps >= cbts_pkg::FAST_BITRATE) ?
		cbts_pkg::FAST_QUANTA : cbts_pkg::SLOW_QUANTA;
	assign early_fail = (req.clock_hz == 32'd0) || (req.bitrate_bps < cbts_pkg::MIN_BITRATE) ||
		({1'b0, quanta_sel} > SegSum);

	// divisor trial
	logic [4:0] s_inc;
	logic       rem_zero, pre_ok;

	assign s_inc    = s_q + 5'd1;
	assign rem_zero = (div_rem_nx == 32'd0);
	assign pre_ok   = (div_quo_nx != 32'd0) && (div_quo_nx <= {21'd0, cbts_pkg::MAX_PRESCALER});

	// segment split
	logic [7:0]  s7;
	logic [4:0]  seg1_a, seg1_b, seg1_f, seg2_w;
	logic [14:0] sp_lhs, sp_rhs;
	logic        sp_high, seg_ok;

	assign s7      = {3'd0, s_q} * 8'd7;
	assign seg1_a  = 5'((s7 + 8'd3) >> 3);
	assign seg1_b  = 5'((s7 - 8'd1) >> 3);
	assign sp_lhs  = cbts_pkg::SP_SCALE * {10'd0, seg1_a + 5'd1};
	assign sp_rhs  = cbts_pkg::SP_LIMIT_NEXT * {10'd0, s_inc};
	assign sp_high = (sp_lhs >= sp_rhs);
	assign seg1_f  = sp_high ? seg1_b : seg1_a;
	assign seg2_w  = s_q - seg1_f;
	assign seg_ok  = (s_q > seg1_a) && (seg1_f >= 5'd1) && (seg1_f <= Seg1Max) &&
		(seg2_w >= 5'd1) && (seg2_w <= Seg2Max);

	logic out_free;
	assign out_free = !rsp_valid_q || rsp.ready;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cbts_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		case (state_q)
			cbts_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = early_fail ? cbts_pkg::ST_FIN : cbts_pkg::ST_DIV_Q;
				end
			end
			cbts_pkg::ST_DIV_Q: begin
				if (div_last) begin
					state_d = cbts_pkg::ST_TRIAL;
				end
			end
			cbts_pkg::ST_TRIAL: begin
				if (div_last) begin
					if (rem_zero) begin
						state_d = pre_ok ? cbts_pkg::ST_SPLIT : cbts_pkg::ST_FIN;
					end else if (s_q <= cbts_pkg::MIN_SEARCH) begin
						state_d = cbts_pkg::ST_FIN;
					end
				end
			end
			cbts_pkg::ST_SPLIT: begin
				state_d = seg_ok ? cbts_pkg::ST_DIV_CHK : cbts_pkg::ST_FIN;
			end
			cbts_pkg::ST_DIV_CHK: begin
				if (div_last) begin
					state_d = cbts_pkg::ST_FIN;
				end
			end
			cbts_pkg::ST_FIN: begin
				if (out_free) begin
					state_d = cbts_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = cbts_pkg::ST_IDLE;
			end
		endcase
	end

	// datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 5'd0;
		end else begin
			case (state_q)
				cbts_pkg::ST_IDLE, cbts_pkg::ST_SPLIT: begin
					cnt_q <= 5'd0;
				end
				cbts_pkg::ST_DIV_Q, cbts_pkg::ST_TRIAL, cbts_pkg::ST_DIV_CHK: begin
					cnt_q <= cnt_q + 5'd1;
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			cbts_pkg::ST_IDLE: begin
				if (req.valid) begin
					clk_q <= req.clock_hz;
					br_q  <= req.bitrate_bps;
					s_q   <= quanta_sel - 5'd1;
					ok_q  <= !early_fail;
					rem_q <= 32'd0;
					quo_q <= req.clock_hz;
					den_q <= req.bitrate_bps;
				end
			end
			cbts_pkg::ST_DIV_Q: begin
				rem_q <= div_rem_nx;
				quo_q <= div_quo_nx;
				if (div_last) begin
					q_q   <= div_quo_nx;
					rem_q <= 32'd0;
					den_q <= {27'd0, s_inc};
				end
			end
			cbts_pkg::ST_TRIAL: begin
				rem_q <= div_rem_nx;
				quo_q <= div_quo_nx;
				if (div_last) begin
					if (rem_zero) begin
						pre_q <= div_quo_nx[10:0];
						ok_q  <= pre_ok;
					end else if (s_q <= cbts_pkg::MIN_SEARCH) begin
						ok_q <= 1'b0;
					end else begin
						s_q   <= s_q - 5'd1;
						rem_q <= 32'd0;
						quo_q <= q_q;
						den_q <= {27'd0, s_q};
					end
				end
			end
			cbts_pkg::ST_SPLIT: begin
				seg1_q <= seg1_f;
				seg2_q <= seg2_w[3:0];
				ok_q   <= seg_ok;
				rem_q  <= 32'd0;
				quo_q  <= clk_q;
				den_q  <= q_q;
			end
			cbts_pkg::ST_DIV_CHK: begin
				rem_q <= div_rem_nx;
				quo_q <= div_quo_nx;
				if (div_last) begin
					ok_q <= (div_quo_nx == br_q);
				end
			end
			default: begin
			end
		endcase
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == cbts_pkg::ST_FIN && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == cbts_pkg::ST_FIN && out_free) begin
			rsp_ok_q   <= ok_q;
			rsp_pre_q  <= ok_q ? pre_q : 11'd0;
			rsp_seg1_q <= ok_q ? seg1_q : 5'd0;
			rsp_seg2_q <= ok_q ? seg2_q : 4'd0;
			rsp_jw_q   <= ok_q;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.ok         = rsp_ok_q;
	assign rsp.prescaler  = rsp_pre_q;
	assign rsp.seg1       = rsp_seg1_q;
	assign rsp.seg2       = rsp_seg2_q;
	assign rsp.jump_width = rsp_jw_q;

endmodule

`default_nettype wire

FILE: rtl/cbts_checker.sv
// cbts_checker: port-level assertions for the CAN bit timing solver
// bound to can_bit_timing_solver; depends on its req / rsp interface ports
`timescale 1ns / 1ps
`default_nettype none

module cbts_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic        rsp_ok,
	input logic [10:0] rsp_prescaler,
	input logic [4:0]  rsp_seg1,
	input logic [3:0]  rsp_seg2,
	input logic        rsp_jump_width
);

	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid &&
		$stable({rsp_ok, rsp_prescaler, rsp_seg1, rsp_seg2, rsp_jump_width}))
		else $error("response changed while stalled");

	// one request in work at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	// a good timing is well formed
	a_ok_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ok |-> rsp_jump_width && (rsp_prescaler != 11'd0) &&
		(rsp_prescaler <= 11'd1024) && (rsp_seg2 != 4'd0) &&
		({1'b0, rsp_seg2} < rsp_seg1))
		else $error("bad fields on good timing");

	// a failure clears all fields
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ok |-> !rsp_jump_width && (rsp_prescaler == 11'd0) &&
		(rsp_seg1 == 5'd0) && (rsp_seg2 == 4'd0))
		else $error("nonzero fields on failure");

endmodule

bind can_bit_timing_solver cbts_checker u_cbts_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_ok         (rsp.ok),
	.rsp_prescaler  (rsp.prescaler),
	.rsp_seg1       (rsp.seg1),
	.rsp_seg2       (rsp.seg2),
	.rsp_jump_width (rsp.jump_width)
);

`default_nettype wire
